// ===== hdl/etrb_pkg.sv =====
// Shared constants and types for the event trace ring buffer.
package etrb_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = 9;
    localparam int ID_W    = 8;
    localparam int AUX_W   = 24;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = ID_W + AUX_W + TIME_W;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    // Bit layout matches the stored word: id on top, timestamp at the bottom.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [AUX_W-1:0]  aux;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } mem_req_t;

endpackage

// ===== hdl/etrb_store.sv =====
// Entry storage: a single-port synchronous memory with a registered read.
module etrb_store (
    input  logic              clk,
    input  etrb_pkg::mem_req_t req,
    output etrb_pkg::entry_t   rdata
);
    import etrb_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/event_trace_ring_buffer_top.sv =====
// Top level of the event trace ring buffer: pointers, count and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | kind, event_id, aux_data, timestamp
//  output   | out_valid / out_stall  | pop_valid, popped_id, popped_aux,
//           |                        | popped_time, overwrote, is_empty, fill_count
//  config   | cfg_we                 | cfg_wdata (capacity)
//
// A request's result is shown in the cycle after the request is accepted.
// The single memory port serves that request's write or read at the accepting
// edge, so with no output stall one request a cycle flows through.
// A held result blocks input: a new request is taken only when the output
// register is empty or is being taken in the same cycle.
// Reset clears pointers, count and the result valid; capacity returns to 256.
// The entry memory is not cleared; a pop can read a slot that was never written.
module event_trace_ring_buffer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [etrb_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [etrb_pkg::ID_W-1:0]     event_id,
    input  logic [etrb_pkg::AUX_W-1:0]    aux_data,
    input  logic [etrb_pkg::TIME_W-1:0]   timestamp,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pop_valid,
    output logic [etrb_pkg::ID_W-1:0]     popped_id,
    output logic [etrb_pkg::AUX_W-1:0]    popped_aux,
    output logic [etrb_pkg::TIME_W-1:0]   popped_time,
    output logic                          overwrote,
    output logic                          is_empty,
    output logic [etrb_pkg::CNT_W-1:0]    fill_count
);
    import etrb_pkg::*;

    logic [CNT_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [ADDR_W-1:0] rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic              pop_valid_reg, pop_valid_next;
    logic              overwrote_reg, overwrote_next;

    logic              in_accept;
    logic              out_taken;
    logic [CNT_W-1:0]  eff_cap;
    logic [ADDR_W-1:0] wr_slot;
    mem_req_t          mem_req;
    entry_t            mem_rdata;

    // Position advance with wrap at the effective capacity.
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] pos,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(pos) + CNT_W'(1);
        return (inc >= cap) ? '0 : inc[ADDR_W-1:0];
    endfunction

    assign out_taken = out_valid_reg && !out_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Capacity zero acts as one; anything past the memory depth acts as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // A write position left beyond a shrunken capacity restarts at slot zero.
    assign wr_slot = (CNT_W'(wr_pos_reg) >= eff_cap) ? '0 : wr_pos_reg;

    always_comb
    begin
        wr_pos_next    = wr_pos_reg;
        rd_pos_next    = rd_pos_reg;
        count_next     = count_reg;
        pop_valid_next = pop_valid_reg;
        overwrote_next = overwrote_reg;
        mem_req        = '0;
        mem_req.wdata  = '{id: event_id, aux: aux_data, stamp: timestamp};

        if (in_accept)
        begin
            pop_valid_next = 1'b0;
            overwrote_next = 1'b0;
            case (kind_t'(kind))
                KIND_PUSH:
                begin
                    mem_req.wr_en = 1'b1;
                    if (count_reg < eff_cap)
                    begin
                        mem_req.addr = wr_slot;
                        wr_pos_next  = advance(wr_slot, eff_cap);
                        count_next   = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // Full: the oldest entry is replaced and both positions move on.
                        mem_req.addr   = rd_pos_reg;
                        rd_pos_next    = advance(rd_pos_reg, eff_cap);
                        wr_pos_next    = rd_pos_next;
                        overwrote_next = 1'b1;
                    end
                end
                KIND_POP:
                begin
                    if (count_reg != '0)
                    begin
                        mem_req.rd_en  = 1'b1;
                        mem_req.addr   = rd_pos_reg;
                        rd_pos_next    = advance(rd_pos_reg, eff_cap);
                        count_next     = count_reg - CNT_W'(1);
                        pop_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    pop_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CNT_W'(DEPTH);
            wr_pos_reg    <= '0;
            rd_pos_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
            overwrote_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            wr_pos_reg    <= wr_pos_next;
            rd_pos_reg    <= rd_pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pop_valid_reg <= pop_valid_next;
            overwrote_reg <= overwrote_next;
        end
    end

    etrb_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // The read register holds until the next pop, so a stalled result stays intact.
    // The count register only changes on acceptance, so it matches the shown result.
    assign out_valid   = out_valid_reg;
    assign pop_valid   = pop_valid_reg;
    assign popped_id   = pop_valid_reg ? mem_rdata.id    : '0;
    assign popped_aux  = pop_valid_reg ? mem_rdata.aux   : '0;
    assign popped_time = pop_valid_reg ? mem_rdata.stamp : '0;
    assign overwrote   = overwrote_reg;
    assign fill_count  = count_reg;
    assign is_empty    = (count_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds memory depth");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overwrote_reg |-> !pop_valid_reg && (count_reg != '0))
        else $error("overwrite reported on a pop or an empty buffer");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (kind == KIND_POP) && (count_reg != '0)
        |=> pop_valid_reg && (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not release exactly one entry");

endmodule

// ===== tb/event_trace_ring_buffer_top_test.sv =====
// Self-checking testbench for the event trace ring buffer top level.
module event_trace_ring_buffer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import etrb_pkg::*;

    // The run is stopped as failed if the cycle counter passes this limit.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // This is the length of the long receiver hold-off. It is long enough that the
    // result register fills and the input side stalls.
    localparam int unsigned HOLD_CYCLES = 300;

    // One result as seen on the output channel.
    typedef struct packed {
        logic               pop_valid;
        logic [ID_W-1:0]    id;
        logic [AUX_W-1:0]   aux;
        logic [TIME_W-1:0]  stamp;
        logic               overwrote;
        logic               is_empty;
        logic [CNT_W-1:0]   fill;
    } trace_result_t;

    // The mirror keeps its own copy of the entry store, the positions, the count and the
    // capacity register. For every accepted request it computes the result that the block
    // must return, and it queues the results in request order.
    class trace_mirror;
        entry_t             slots [DEPTH];
        bit                 written [DEPTH];
        int unsigned        wr_pos;
        int unsigned        rd_pos;
        int unsigned        held;
        int unsigned        cap_reg = 256;
        trace_result_t      awaited [$];
        int unsigned        errors;
        int unsigned        n_push;
        int unsigned        n_over;
        int unsigned        n_pop;
        int unsigned        n_empty_pop;
        int unsigned        n_cfg;

        function int unsigned usable_slots();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > DEPTH)
                return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_pos(int unsigned pos, int unsigned cap);
            return (pos + 1 >= cap) ? 0 : pos + 1;
        endfunction

        function void set_capacity(logic [CNT_W-1:0] value);
            cap_reg = int'(value);
            n_cfg++;
        endfunction

        // A pop of a held entry must never land on a slot that was never written.
        function bit pop_hits_blank();
            return held != 0 && !written[rd_pos];
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_request(kind_t k, logic [ID_W-1:0] id, logic [AUX_W-1:0] aux,
                                   logic [TIME_W-1:0] stamp);
            trace_result_t r;
            entry_t        e;
            int unsigned   cap;
            r = '0;
            cap = usable_slots();
            e.id = id;
            e.aux = aux;
            e.stamp = stamp;
            if (k == KIND_PUSH) begin
                n_push++;
                if (held < cap) begin
                    // A position left beyond a shrunken capacity restarts at slot zero.
                    if (wr_pos >= cap)
                        wr_pos = 0;
                    slots[wr_pos] = e;
                    written[wr_pos] = 1'b1;
                    wr_pos = step_pos(wr_pos, cap);
                    held++;
                end else begin
                    // Full: the oldest entry is replaced and both positions move on.
                    slots[rd_pos] = e;
                    written[rd_pos] = 1'b1;
                    rd_pos = step_pos(rd_pos, cap);
                    wr_pos = rd_pos;
                    r.overwrote = 1'b1;
                    n_over++;
                end
            end else if (held != 0) begin
                e = slots[rd_pos];
                rd_pos = step_pos(rd_pos, cap);
                held--;
                r.pop_valid = 1'b1;
                r.id = e.id;
                r.aux = e.aux;
                r.stamp = e.stamp;
                n_pop++;
            end else begin
                n_empty_pop++;
            end
            r.is_empty = (held == 0);
            r.fill = held[CNT_W-1:0];
            awaited.push_back(r);
        endfunction

        task check_result(trace_result_t got);
            trace_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.pop_valid !== want.pop_valid)
                report_mismatch($sformatf("pop_valid %0b, expected %0b",
                                          got.pop_valid, want.pop_valid));
            if (got.id !== want.id)
                report_mismatch($sformatf("popped_id %h, expected %h", got.id, want.id));
            if (got.aux !== want.aux)
                report_mismatch($sformatf("popped_aux %h, expected %h", got.aux, want.aux));
            if (got.stamp !== want.stamp)
                report_mismatch($sformatf("popped_time %h, expected %h",
                                          got.stamp, want.stamp));
            if (got.overwrote !== want.overwrote)
                report_mismatch($sformatf("overwrote %0b, expected %0b",
                                          got.overwrote, want.overwrote));
            if (got.is_empty !== want.is_empty)
                report_mismatch($sformatf("is_empty %0b, expected %0b",
                                          got.is_empty, want.is_empty));
            if (got.fill !== want.fill)
                report_mismatch($sformatf("fill_count %0d, expected %0d", got.fill, want.fill));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = 1'b0;
    logic [ID_W-1:0]    event_id = '0;
    logic [AUX_W-1:0]   aux_data = '0;
    logic [TIME_W-1:0]  timestamp = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               pop_valid;
    logic [ID_W-1:0]    popped_id;
    logic [AUX_W-1:0]   popped_aux;
    logic [TIME_W-1:0]  popped_time;
    logic               overwrote;
    logic               is_empty;
    logic [CNT_W-1:0]   fill_count;

    // These are the idle rates of the two sides, in percent. The main sequence sets them.
    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_idle_pct = 0;
    // The main sequence bumps this count to ask the result side for one long hold-off.
    int unsigned        hold_asked = 0;
    int unsigned        cycles = 0;

    trace_mirror        ledger = new();

    event_trace_ring_buffer_top uut (.*);

    always #4 clk = ~clk;

    // This process is the watchdog. A run that hangs is a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ledger.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // This process is the result side. Outputs are sampled at the rising edge, before the
    // block's registers update, and a result counts as taken when valid is high and the
    // stall was low. The stall for the next cycle is chosen at the same edge. A requested
    // hold-off is counted out here, in this process, while the request side keeps
    // offering requests.
    always @(posedge clk) begin : result_side
        int unsigned hold_left;
        int unsigned hold_done;
        if (rst_n) begin
            if (out_valid && !out_stall)
                ledger.check_result('{pop_valid, popped_id, popped_aux, popped_time,
                                      overwrote, is_empty, fill_count});
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_done != hold_asked) begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    // This function returns a random field value. It often returns the all-zero and
    // all-one extremes.
    function automatic logic [31:0] field_value(int unsigned bits);
        logic [31:0]  mask;
        int unsigned  pick;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        pick = $urandom_range(9);
        if (pick == 0)
            return 32'd0;
        if (pick == 1)
            return mask;
        return $urandom & mask;
    endfunction

    // This task offers one request and returns at the edge that accepts it. It must be
    // called right after a rising edge. Valid stays high after acceptance, so requests
    // can follow back to back. It is lowered when the next call idles, or by the caller. A pop that
    // would read a slot never written is turned into a push.
    task automatic issue(kind_t k, logic [ID_W-1:0] id, logic [AUX_W-1:0] aux,
                         logic [TIME_W-1:0] stamp);
        if (k == KIND_POP && ledger.pop_hits_blank())
            k = KIND_PUSH;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        event_id <= id;
        aux_data <= aux;
        timestamp <= stamp;
        do
            @(posedge clk);
        while (in_stall);
        ledger.note_request(k, id, aux, stamp);
    endtask

    task automatic issue_random(kind_t k);
        issue(k, ID_W'(field_value(ID_W)), AUX_W'(field_value(AUX_W)),
              TIME_W'(field_value(TIME_W)));
    endtask

    // The capacity is written only when no result is outstanding. Every request gives
    // exactly one result, so an empty queue means that the block is idle.
    task automatic apply_capacity(logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        ledger.set_capacity(value);
    endtask

    // A random phase is made of bursts. Each burst leans toward pushes, toward pops, or
    // is balanced. This lets the buffer fill to overwriting, drain to empty, and run
    // pops on the empty buffer.
    task automatic run_phase(logic [CNT_W-1:0] cap, int unsigned count);
        int unsigned burst_left;
        int unsigned push_pct;
        burst_left = 0;
        push_pct = 50;
        apply_capacity(cap);
        for (int unsigned i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(4, 40);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            burst_left--;
            issue_random(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP);
        end
    endtask

    initial begin
        // Reset is held low from time zero and then released. It is never asserted again.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // In the first stretch the request side idles a little and the result side
        // idles a lot.
        tx_idle_pct = 20;
        rx_idle_pct = 75;

        // The directed part starts at full capacity. It pops the empty buffer, stores
        // entries with all-zero and all-one fields, reads them back and pops empty again.
        apply_capacity(9'd256);
        issue_random(KIND_POP);
        issue(KIND_PUSH, '0, '0, '0);
        issue(KIND_PUSH, '1, '1, '1);
        issue_random(KIND_PUSH);
        issue_random(KIND_POP);
        issue_random(KIND_POP);
        issue_random(KIND_POP);
        issue_random(KIND_POP);

        // With one slot, every push after the first replaces the entry that is held.
        apply_capacity(9'd1);
        issue_random(KIND_PUSH);
        issue_random(KIND_PUSH);
        issue_random(KIND_POP);
        issue_random(KIND_POP);

        // A capacity of zero must behave as a capacity of one.
        apply_capacity(9'd0);
        issue_random(KIND_PUSH);
        issue_random(KIND_PUSH);
        issue_random(KIND_POP);

        // The buffer is filled past a capacity of four. The capacity then shrinks while
        // entries are held, so the count sits above the new capacity until pops drain it.
        apply_capacity(9'd4);
        repeat (5) issue_random(KIND_PUSH);
        apply_capacity(9'd2);
        issue_random(KIND_PUSH);
        repeat (5) issue_random(KIND_POP);

        run_phase(9'd37, 250);
        run_phase(9'd256, 250);

        // Now the request side idles a lot and the result side idles a little. Capacity
        // values above the depth must act as the full depth.
        tx_idle_pct = 75;
        rx_idle_pct = 20;
        run_phase(9'd511, 250);
        run_phase(9'd2, 250);
        run_phase(9'd0, 150);

        // In the last stretch neither side idles. The long hold-off happens at the start of
        // this stretch. The result register fills and the block stalls its input while
        // requests keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_capacity(9'd8);
        hold_asked++;
        run_phase(9'd8, 250);

        // Pushes alone take the full-depth buffer up to 256 entries and on into
        // overwriting.
        apply_capacity(9'd511);
        repeat (270) issue_random(KIND_PUSH);
        run_phase(9'd256, 100);
        run_phase(9'($urandom_range(3, 255)), 150);

        // The stimulus is done. The test waits for the last results and then lets the clock
        // run on, so that a stray result would still be caught.
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d pushes, %0d of them overwriting, %0d pops with data",
                 ledger.n_push, ledger.n_over, ledger.n_pop);
        $display("and %0d empty pops; capacity written %0d times, %0d mismatches.",
                 ledger.n_empty_pop, ledger.n_cfg, ledger.errors);
        if (ledger.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
